/* sv/slpd_pkg.sv */
// Shared types and constants for the Sierra Lite palette dither core.
// No dependencies; every other file in sv/ refers to it by scoped names.
`default_nettype none

package slpd_pkg;

  // One 8-bit color channel and an RGB triple, red in [2], blue in [0]
  typedef logic [7:0] chan_t;
  typedef chan_t [2:0] rgb_t;

  // Carried error of one channel and a triple of them (one error line word)
  typedef logic signed [9:0] err_t;
  typedef err_t [2:0] err_rgb_t;

  // Arithmetic widths
  localparam int SUM_W  = 11;  // pixel + line error + right error
  localparam int SQ_W   = 16;  // one squared channel difference
  localparam int DIST_W = 18;  // sum of three squares
  localparam int IDX_W  = 8;   // palette index on the result port

  // Input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 2'd2;

  // Pixel sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_START,
    ST_WAIT,
    ST_DIFF,
    ST_EDGE,
    ST_EMIT
  } state_t;

  // Status of the palette search unit
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] index;
    rgb_t             rgb;
  } search_res_t;

  // Write request into the error line
  typedef struct packed {
    logic     en;
    err_rgb_t data;
  } line_wr_t;

endpackage

`default_nettype wire

/* sv/slpd_search.sv */
// Palette memory and the nearest-entry search unit (one entry per cycle).
// Depends on slpd_pkg.
`default_nettype none

module slpd_search #(
  parameter int PALETTE_DEPTH = 256,
  parameter int PW = $clog2(PALETTE_DEPTH),
  parameter int SW = $clog2(PALETTE_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 pal_we,
  input  wire logic [PW-1:0]        pal_waddr,
  input  wire slpd_pkg::rgb_t       pal_wdata,
  input  wire logic                 start,
  input  wire logic [SW-1:0]        count,
  input  wire slpd_pkg::rgb_t       target,
  output slpd_pkg::search_res_t     res
);

  // Palette storage, one synchronous read port
  slpd_pkg::rgb_t mem [PALETTE_DEPTH];
  slpd_pkg::rgb_t q_r;

  // Issue stage
  logic          issue_r;
  logic [PW-1:0] issue_idx_r;
  logic          issue_last;

  // Stage A: read data returned
  logic          va_r, la_r;
  logic [PW-1:0] ia_r;

  // Stage B: squared differences
  logic                      vb_r, lb_r;
  logic [PW-1:0]             ib_r;
  slpd_pkg::rgb_t            cb_r;
  logic [slpd_pkg::SQ_W-1:0] sq_b_r [3];
  logic [slpd_pkg::SQ_W-1:0] sq_nxt [3];

  // Stage C: running best
  logic [slpd_pkg::DIST_W-1:0] dist_b;
  logic [slpd_pkg::DIST_W-1:0] best_d_r;
  logic [PW-1:0]               best_idx_r;
  slpd_pkg::rgb_t              best_rgb_r;
  logic                        done_r;

  always_ff @(posedge clk) begin
    if (pal_we) begin
      mem[pal_waddr] <= pal_wdata;
    end
    q_r <= mem[issue_idx_r];
  end

  assign issue_last = (SW'(issue_idx_r) + SW'(1)) == count;

  // Address sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r     <= 1'b0;
      issue_idx_r <= '0;
    end else if (start) begin
      issue_r     <= 1'b1;
      issue_idx_r <= '0;
    end else if (issue_r) begin
      if (issue_last) begin
        issue_r <= 1'b0;
      end else begin
        issue_idx_r <= issue_idx_r + PW'(1);
      end
    end
  end

  // Squares of the channel differences
  always_comb begin
    logic signed [8:0]  d;
    logic signed [17:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      d = $signed({1'b0, target[ch]}) - $signed({1'b0, q_r[ch]});
      p = d * d;
      sq_nxt[ch] = p[slpd_pkg::SQ_W-1:0];
    end
  end

  assign dist_b = slpd_pkg::DIST_W'(sq_b_r[0]) + slpd_pkg::DIST_W'(sq_b_r[1])
                + slpd_pkg::DIST_W'(sq_b_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      la_r   <= 1'b0;
      vb_r   <= 1'b0;
      lb_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      va_r   <= issue_r;
      la_r   <= issue_r && issue_last;
      vb_r   <= va_r;
      lb_r   <= la_r;
      done_r <= vb_r && lb_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    ia_r <= issue_idx_r;
    ib_r <= ia_r;
    cb_r <= q_r;
    for (int ch = 0; ch < 3; ch++) begin
      sq_b_r[ch] <= sq_nxt[ch];
    end
    // Entry 0 always seeds the best; later entries win only when strictly nearer
    if (vb_r && (ib_r == '0 || dist_b < best_d_r)) begin
      best_d_r   <= dist_b;
      best_idx_r <= ib_r;
      best_rgb_r <= cb_r;
    end
  end

  assign res.done  = done_r;
  assign res.index = slpd_pkg::IDX_W'(best_idx_r);
  assign res.rgb   = best_rgb_r;

endmodule

`default_nettype wire

/* sv/slpd_err_line.sv */
// Error line memory: one carried error triple per column, with a clearing pass.
// Depends on slpd_pkg.
`default_nettype none

module slpd_err_line #(
  parameter int MAX_WIDTH = 4096,
  parameter int COLW = $clog2(MAX_WIDTH)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clear,
  output logic                     busy,
  input  wire logic [COLW-1:0]     rd_addr,
  output slpd_pkg::err_rgb_t       rd_data,
  input  wire logic [COLW-1:0]     wr_addr,
  input  wire slpd_pkg::line_wr_t  wr
);

  slpd_pkg::err_rgb_t mem [MAX_WIDTH];
  slpd_pkg::err_rgb_t rd_q_r;

  logic            busy_r;
  logic [COLW-1:0] clr_idx_r;

  // Clearing pass after reset and on request
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      if (clr_idx_r == COLW'(MAX_WIDTH - 1)) begin
        busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + COLW'(1);
      end
    end
  end

  // Storage: the sweep owns the write port while busy
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign busy    = busy_r;
  assign rd_data = rd_q_r;

endmodule

`default_nettype wire

/* sv/sierra_lite_palette_dither_core.sv */
// Top level of the Sierra Lite palette dither core: registers, pixel sequencer,
// error diffusion and result register. Depends on slpd_pkg, slpd_search, slpd_err_line.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid/in_ready, in_cmd, entry, pixel   | request in
//   out     | out_valid/out_ready, palette_index, end   | result out
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register write
//
// A palette load leaves the block idle. A pixel passes the load, sum, start, wait,
// diff, edge (last column of a row only) and emit states, the search reading one
// palette entry per cycle. Reset and writes to frame width, height or palette size
// start a clearing pass of the error line (in_ready low). cfg_ready is always high.
// A finished result waits in the output register; the next request is taken
// meanwhile and its result holds in the last state until the register frees.
`default_nettype none

module sierra_lite_palette_dither_core #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input requests
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_cmd,
  input  wire logic [7:0]                     in_entry_index,
  input  wire logic [7:0]                     in_entry_red,
  input  wire logic [7:0]                     in_entry_green,
  input  wire logic [7:0]                     in_entry_blue,
  input  wire logic [7:0]                     in_pixel_red,
  input  wire logic [7:0]                     in_pixel_green,
  input  wire logic [7:0]                     in_pixel_blue,
  // results
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_palette_index,
  output logic                                out_frame_end,
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [slpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [slpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int PW   = $clog2(PALETTE_DEPTH);
  localparam int SW   = $clog2(PALETTE_DEPTH + 1);

  // Configuration
  logic [12:0] frame_width_r;
  logic [15:0] frame_height_r;
  logic [8:0]  palette_size_r;
  logic        cfg_acc;
  logic        restart;

  logic [EW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic [SW-1:0] eff_n;

  // Sequencer
  slpd_pkg::state_t state_r, state_nxt;
  logic             in_acc;
  logic             line_busy;

  // Position and carried errors
  logic [COLW-1:0]     col_r;
  logic [15:0]         row_r;
  logic                last_col, last_row;
  slpd_pkg::err_rgb_t  right_r, below_r;
  slpd_pkg::rgb_t      pix_r, v_r, v_nxt;
  slpd_pkg::err_rgb_t  half, quarter, line_prev;

  // Submodule connections
  slpd_pkg::err_rgb_t    line_q;
  slpd_pkg::line_wr_t    line_wr;
  logic [COLW-1:0]       line_waddr;
  slpd_pkg::search_res_t sres;
  logic                  search_start;
  logic                  pal_we;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_idx_r;
  logic       out_end_r;
  logic       emit;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign restart   = cfg_acc && (cfg_index == slpd_pkg::CFG_FRAME_WIDTH
                               || cfg_index == slpd_pkg::CFG_FRAME_HEIGHT
                               || cfg_index == slpd_pkg::CFG_PALETTE_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd1;
      frame_height_r <= 16'd1;
      palette_size_r <= 9'd1;
    end else if (cfg_acc) begin
      case (cfg_index)
        slpd_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[12:0];
        slpd_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[15:0];
        slpd_pkg::CFG_PALETTE_SIZE: palette_size_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Effective register values: zero counts as one, capped at the build limits
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = EW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(frame_width_r);
    end
    eff_h = (frame_height_r == '0) ? 16'd1 : frame_height_r;
    if (palette_size_r == '0) begin
      eff_n = SW'(1);
    end else if (32'(palette_size_r) > 32'(PALETTE_DEPTH)) begin
      eff_n = SW'(PALETTE_DEPTH);
    end else begin
      eff_n = SW'(palette_size_r);
    end
  end

  assign in_ready = (state_r == slpd_pkg::ST_IDLE) && !line_busy;
  assign in_acc   = in_valid && in_ready;
  assign pal_we   = in_acc && (in_cmd == slpd_pkg::CMD_LOAD)
                 && (32'(in_entry_index) < 32'(PALETTE_DEPTH));

  assign last_col = ({1'b0, EW'(col_r)} + (EW + 1)'(1)) >= {1'b0, eff_w};
  assign last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, eff_h};

  // Carried error added and clamped per channel
  always_comb begin
    logic signed [slpd_pkg::SUM_W-1:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = $signed({3'b000, pix_r[ch]}) + slpd_pkg::SUM_W'(line_q[ch])
        + slpd_pkg::SUM_W'(right_r[ch]);
      if (s < 0) begin
        v_nxt[ch] = 8'd0;
      end else if (s > $signed(slpd_pkg::SUM_W'(255))) begin
        v_nxt[ch] = 8'd255;
      end else begin
        v_nxt[ch] = s[7:0];
      end
    end
  end

  // Quantization error split into shares, truncated toward zero
  always_comb begin
    slpd_pkg::err_t e;
    for (int ch = 0; ch < 3; ch++) begin
      e = $signed({2'b00, v_r[ch]}) - $signed({2'b00, sres.rgb[ch]});
      half[ch]      = e / 10'sd2;
      quarter[ch]   = last_row ? 10'sd0 : e / 10'sd4;
      line_prev[ch] = $signed(below_r[ch]) + $signed(quarter[ch]);
    end
  end

  // Next state and per-state controls
  always_comb begin
    state_nxt    = state_r;
    search_start = 1'b0;
    line_wr.en   = 1'b0;
    line_wr.data = line_prev;
    line_waddr   = col_r - COLW'(1);
    emit         = 1'b0;
    unique case (state_r)
      slpd_pkg::ST_IDLE: begin
        if (in_acc && in_cmd == slpd_pkg::CMD_PIXEL) begin
          state_nxt = slpd_pkg::ST_LOAD;
        end
      end
      slpd_pkg::ST_LOAD:  state_nxt = slpd_pkg::ST_SUM;
      slpd_pkg::ST_SUM:   state_nxt = slpd_pkg::ST_START;
      slpd_pkg::ST_START: begin
        search_start = 1'b1;
        state_nxt    = slpd_pkg::ST_WAIT;
      end
      slpd_pkg::ST_WAIT: begin
        if (sres.done) begin
          state_nxt = slpd_pkg::ST_DIFF;
        end
      end
      slpd_pkg::ST_DIFF: begin
        // below-left share joins the pending one
        line_wr.en = (col_r != '0);
        state_nxt  = last_col ? slpd_pkg::ST_EDGE : slpd_pkg::ST_EMIT;
      end
      slpd_pkg::ST_EDGE: begin
        // last column: its below share lands in the current column
        line_wr.en   = 1'b1;
        line_wr.data = below_r;
        line_waddr   = col_r;
        state_nxt    = slpd_pkg::ST_EMIT;
      end
      slpd_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = slpd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Position, carried errors and pixel registers
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r   <= '0;
      row_r   <= '0;
      right_r <= '0;
      below_r <= '0;
    end else begin
      if (in_acc && in_cmd == slpd_pkg::CMD_PIXEL) begin
        if (EW'(col_r) >= eff_w) begin
          col_r <= '0;
        end
        if (row_r >= eff_h) begin
          row_r <= '0;
        end
      end
      if (state_r == slpd_pkg::ST_DIFF) begin
        below_r <= quarter;
        right_r <= last_col ? '0 : half;
      end
      if (emit) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? 16'd0 : row_r + 16'd1;
        end else begin
          col_r <= col_r + COLW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= {in_pixel_red, in_pixel_green, in_pixel_blue};
    end
    if (state_r == slpd_pkg::ST_SUM) begin
      v_r <= v_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r <= sres.index;
      out_end_r <= last_row && last_col;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = out_idx_r;
  assign out_frame_end     = out_end_r;

  slpd_search #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .PW            (PW),
    .SW            (SW)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .pal_we    (pal_we),
    .pal_waddr (in_entry_index[PW-1:0]),
    .pal_wdata ({in_entry_red, in_entry_green, in_entry_blue}),
    .start     (search_start),
    .count     (eff_n),
    .target    (v_r),
    .res       (sres)
  );

  slpd_err_line #(
    .MAX_WIDTH (MAX_WIDTH),
    .COLW      (COLW)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (restart),
    .busy    (line_busy),
    .rd_addr (col_r),
    .rd_data (line_q),
    .wr_addr (line_waddr),
    .wr      (line_wr)
  );

endmodule

`default_nettype wire

/* sv/slpd_checker.sv */
// Port-level checks for the palette dither core, bound to its top level.
// Depends on slpd_pkg and sierra_lite_palette_dither_core.
`default_nettype none

module slpd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           in_cmd,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [slpd_pkg::CFG_IDX_W-1:0]  cfg_index
);

  // A result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the result was taken");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A pixel request occupies the block for the following cycle
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == slpd_pkg::CMD_PIXEL |=> !in_ready)
    else $error("request taken right after a pixel");

  // A write to frame width, frame height or palette size starts the clearing pass
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == slpd_pkg::CFG_FRAME_WIDTH
      || cfg_index == slpd_pkg::CFG_FRAME_HEIGHT
      || cfg_index == slpd_pkg::CFG_PALETTE_SIZE) |=> !in_ready)
    else $error("request taken during the error line clearing pass");

endmodule

bind sierra_lite_palette_dither_core slpd_checker u_slpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_cmd    (in_cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);

`default_nettype wire

/* dv/tb_sierra_lite_palette_dither_core.sv */
// Self-checking testbench for sierra_lite_palette_dither_core: palette loads, dithered pixels,
// register phases and random stalls on both channels, checked against an in-bench predictor.
// Depends on slpd_pkg and the core RTL in sv/.
`default_nettype none

module tb_sierra_lite_palette_dither_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W     = 4096;
  localparam int PAL_DEPTH = 256;
  localparam int ITEMS     = 900;
  localparam int SETTLE    = 300;    // longer than one pixel at the largest palette
  localparam int WATCHDOG  = 40000;  // cycles without any handshake
  localparam int HOLD_AT   = 120;    // result count that starts the long receiver hold-off
  localparam int HOLD_LEN  = 2000;
  localparam int MAX_REPORTS = 40;
  localparam logic [slpd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One input request as queued for the driver
  typedef struct {
    logic       cmd;
    logic [7:0] slot;
    logic [7:0] ent_r, ent_g, ent_b;
    logic [7:0] pix_r, pix_g, pix_b;
    bit         drain;  // hold this request until every owed result has come
  } dither_req_t;

  typedef struct {
    logic [7:0] pal_index;
    logic       frame_end;
  } dither_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = slpd_pkg::CMD_LOAD;
  logic [7:0] in_entry_index = '0;
  logic [7:0] in_entry_red = '0;
  logic [7:0] in_entry_green = '0;
  logic [7:0] in_entry_blue = '0;
  logic [7:0] in_pixel_red = '0;
  logic [7:0] in_pixel_green = '0;
  logic [7:0] in_pixel_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_palette_index;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [slpd_pkg::CFG_IDX_W-1:0] cfg_index = slpd_pkg::CFG_FRAME_WIDTH;
  logic [slpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sierra_lite_palette_dither_core #(
    .MAX_WIDTH(MAX_W),
    .PALETTE_DEPTH(PAL_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_entry_index(in_entry_index),
    .in_entry_red(in_entry_red),
    .in_entry_green(in_entry_green),
    .in_entry_blue(in_entry_blue),
    .in_pixel_red(in_pixel_red),
    .in_pixel_green(in_pixel_green),
    .in_pixel_blue(in_pixel_blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_palette_index(out_palette_index),
    .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor state
  int cur_w, cur_h, cur_n;
  logic [7:0] pal_rgb [PAL_DEPTH][3];
  int line_err [MAX_W][3];
  int right_err [3];
  int below_pend [3];
  int col, row;

  dither_req_t req_queue [$];
  dither_res_t predicted_px [$];
  int owed = 0;  // pixel requests accepted whose result has not come yet

  bit pal_loaded [PAL_DEPTH];
  bit calm = 1'b0;
  int items_queued = 0;
  int fail_count = 0;
  int px_checked = 0;
  int loads_seen = 0;
  int frames_seen = 0;
  int settings_seen = 0;
  int rx_count = 0;
  int hold_left = 0;
  int quiet = 0;
  dither_req_t drv_req;

  // New frame: position and every carried error back to zero
  function automatic void restart_frame();
    for (int x = 0; x < MAX_W; x++) begin
      for (int ch = 0; ch < 3; ch++) line_err[x][ch] = 0;
    end
    for (int ch = 0; ch < 3; ch++) begin
      right_err[ch] = 0;
      below_pend[ch] = 0;
    end
    col = 0;
    row = 0;
  endfunction

  function automatic void apply_reg(input logic [slpd_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [slpd_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      slpd_pkg::CFG_FRAME_WIDTH:  cur_w = int'(data[12:0]);
      slpd_pkg::CFG_FRAME_HEIGHT: cur_h = int'(data);
      slpd_pkg::CFG_PALETTE_SIZE: cur_n = int'(data[8:0]);
      default: return;
    endcase
    restart_frame();
  endfunction

  // Nearest-entry search and Sierra Lite spreading for one pixel
  function automatic void dither_pixel(input int pr, input int pg, input int pb,
                                       output logic [7:0] idx_o, output logic end_o);
    int w, h, n, c, best, d, e, err, half, qtr, pick;
    int px [3];
    int v [3];
    bit last_row, last_col;
    w = (cur_w < 1) ? 1 : ((cur_w > MAX_W) ? MAX_W : cur_w);
    h = (cur_h < 1) ? 1 : cur_h;
    n = (cur_n < 1) ? 1 : ((cur_n > PAL_DEPTH) ? PAL_DEPTH : cur_n);
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    c = col;
    last_row = (row + 1 >= h);
    last_col = (c + 1 >= w);
    px[0] = pr;
    px[1] = pg;
    px[2] = pb;
    for (int ch = 0; ch < 3; ch++) begin
      v[ch] = px[ch] + line_err[c][ch] + right_err[ch];
      if (v[ch] < 0) v[ch] = 0;
      if (v[ch] > 255) v[ch] = 255;
    end
    // lowest index wins ties, entry 0 always seeds the search
    pick = 0;
    best = 0;
    for (int i = 0; i < n; i++) begin
      d = 0;
      for (int ch = 0; ch < 3; ch++) begin
        e = v[ch] - int'(pal_rgb[i][ch]);
        d += e * e;
      end
      if (i == 0 || d < best) begin
        best = d;
        pick = i;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      err = v[ch] - int'(pal_rgb[pick][ch]);
      half = (err * 2) / 4;
      qtr = err / 4;
      if (last_row) qtr = 0;
      if (c > 0) line_err[c-1][ch] = below_pend[ch] + qtr;
      below_pend[ch] = qtr;
      if (last_col) begin
        line_err[c][ch] = below_pend[ch];
        right_err[ch] = 0;
      end else begin
        right_err[ch] = half;
      end
    end
    idx_o = 8'(pick);
    end_o = last_row && last_col;
    if (last_col) begin
      col = 0;
      row = last_row ? 0 : row + 1;
    end else begin
      col = c + 1;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      1: return 8'($urandom_range(0, 7) * 32);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_load(input int slot, input logic [7:0] r, g, b);
    dither_req_t q;
    q.cmd = slpd_pkg::CMD_LOAD;
    q.slot = 8'(slot);
    q.ent_r = r;
    q.ent_g = g;
    q.ent_b = b;
    q.pix_r = 8'($urandom_range(0, 255));
    q.pix_g = 8'($urandom_range(0, 255));
    q.pix_b = 8'($urandom_range(0, 255));
    q.drain = 1'b0;
    pal_loaded[slot] = 1'b1;
    req_queue.push_back(q);
    items_queued++;
  endfunction

  function automatic void queue_pixel(input logic [7:0] r, g, b, input bit drain);
    dither_req_t q;
    q.cmd = slpd_pkg::CMD_PIXEL;
    q.slot = 8'($urandom_range(0, 255));
    q.ent_r = 8'($urandom_range(0, 255));
    q.ent_g = 8'($urandom_range(0, 255));
    q.ent_b = 8'($urandom_range(0, 255));
    q.pix_r = r;
    q.pix_g = g;
    q.pix_b = b;
    q.drain = drain;
    req_queue.push_back(q);
    items_queued++;
  endfunction

  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [slpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slpd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Idle the block, write all three registers in a random rotation, then load any
  // slot the search will read that has never been written
  task automatic start_phase(input int w, input int h, input int n);
    logic [slpd_pkg::CFG_IDX_W-1:0] regs [3];
    logic [slpd_pkg::CFG_DATA_W-1:0] vals [3];
    int first, eff_n;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    regs[0] = slpd_pkg::CFG_FRAME_WIDTH;
    regs[1] = slpd_pkg::CFG_FRAME_HEIGHT;
    regs[2] = slpd_pkg::CFG_PALETTE_SIZE;
    vals[0] = {3'($urandom_range(0, 7)), 13'(w)};
    vals[1] = 16'(h);
    vals[2] = {7'($urandom_range(0, 127)), 9'(n)};
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
    first = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) write_reg(regs[(first + k) % 3], vals[(first + k) % 3]);
    settings_seen++;
    @(negedge clk);
    eff_n = (n < 1) ? 1 : ((n > PAL_DEPTH) ? PAL_DEPTH : n);
    for (int i = 0; i < eff_n; i++) begin
      if (!pal_loaded[i]) queue_load(i, pick_chan(), pick_chan(), pick_chan());
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 13) &&
          !(req_queue[0].drain && (in_valid || owed != 0))) begin
        drv_req = req_queue.pop_front();
        in_valid <= 1'b1;
        in_cmd <= drv_req.cmd;
        in_entry_index <= drv_req.slot;
        in_entry_red <= drv_req.ent_r;
        in_entry_green <= drv_req.ent_g;
        in_entry_blue <= drv_req.ent_b;
        in_pixel_red <= drv_req.pix_r;
        in_pixel_green <= drv_req.pix_g;
        in_pixel_blue <= drv_req.pix_b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_count = rx_count + 1;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (out_valid && out_ready && rx_count == HOLD_AT) begin
        // long hold-off so the core backs up and stalls its input
        out_ready <= 1'b0;
        hold_left <= HOLD_LEN;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // ---------------------------------------------------------------- monitor and checker
  always @(posedge clk) begin : scoreboard
    logic [7:0] want_idx;
    logic want_end;
    dither_res_t want;
    int inc, dec;
    if (rst_n) begin
      inc = 0;
      dec = 0;
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        if (in_cmd == slpd_pkg::CMD_LOAD) begin
          if (int'(in_entry_index) < PAL_DEPTH) begin
            pal_rgb[in_entry_index][0] = in_entry_red;
            pal_rgb[in_entry_index][1] = in_entry_green;
            pal_rgb[in_entry_index][2] = in_entry_blue;
          end
          loads_seen++;
        end else begin
          dither_pixel(int'(in_pixel_red), int'(in_pixel_green), int'(in_pixel_blue),
                       want_idx, want_end);
          predicted_px.push_back('{pal_index: want_idx, frame_end: want_end});
          inc = 1;
        end
      end
      if (out_valid && out_ready) begin
        if (predicted_px.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("result with no pixel request pending: index %0d frame_end %0b",
                   out_palette_index, out_frame_end);
        end else begin
          want = predicted_px.pop_front();
          dec = 1;
          px_checked++;
          if (out_frame_end) frames_seen++;
          if (out_palette_index !== want.pal_index) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("palette_index: expected %0d, got %0d", want.pal_index, out_palette_index);
          end
          if (out_frame_end !== want.frame_end) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
          end
        end
      end
      owed <= owed + inc - dec;
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("timeout: no handshake for %0d cycles, %0d results owed", quiet, owed);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int sel, w, h, n, ew, eh, npx, rnd_phase;
    cur_w = 1;
    cur_h = 1;
    cur_n = 1;
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 3x2 frame: black, white, grey and a repeated grey for the tie rule
    queue_load(0, 8'd0, 8'd0, 8'd0);
    queue_load(1, 8'd255, 8'd255, 8'd255);
    queue_load(2, 8'd128, 8'd128, 8'd128);
    queue_load(3, 8'd128, 8'd128, 8'd128);
    start_phase(3, 2, 4);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    queue_pixel(8'd100, 8'd200, 8'd50, 1'b1);
    queue_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);

    // all registers zero: each counts as one, every pixel ends a frame
    start_phase(0, 0, 0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd37, 8'd150, 8'd255, 1'b0);

    // largest distance, two equal entries: entry 0 must win
    queue_load(1, 8'd0, 8'd0, 8'd0);
    start_phase(2, 1, 2);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);

    // random phases, the first three at the register extremes
    rnd_phase = 0;
    while (items_queued < ITEMS) begin
      case (rnd_phase)
        0: begin w = 8191; h = 65535; n = 511; end
        1: begin w = 4096; h = 1; n = 256; end
        2: begin w = 1; h = 65535; n = 1; end
        default: begin
          sel = $urandom_range(0, 99);
          w = (sel < 60) ? $urandom_range(1, 6) : (sel < 75) ? $urandom_range(7, 40) :
              (sel < 85) ? 4096 : (sel < 90) ? $urandom_range(4097, 8191) : 0;
          sel = $urandom_range(0, 99);
          h = (sel < 60) ? $urandom_range(1, 5) : (sel < 80) ? $urandom_range(6, 20) :
              (sel < 90) ? 0 : 65535;
          sel = $urandom_range(0, 99);
          n = (sel < 70) ? $urandom_range(1, 8) : (sel < 85) ? $urandom_range(9, 40) :
              (sel < 90) ? 256 : (sel < 95) ? $urandom_range(257, 511) : 0;
        end
      endcase
      start_phase(w, h, n);
      calm = (rnd_phase % 8 == 5);
      ew = (w < 1) ? 1 : ((w > MAX_W) ? MAX_W : w);
      eh = (h < 1) ? 1 : h;
      if (ew * eh <= 40) npx = ew * eh * $urandom_range(1, 2) + $urandom_range(0, ew - 1);
      else npx = $urandom_range(15, 45);
      for (int k = 0; k < npx; k++) begin
        // occasional palette change in the middle of a frame
        if ($urandom_range(0, 99) < 5)
          queue_load($urandom_range(0, PAL_DEPTH - 1), pick_chan(), pick_chan(), pick_chan());
        queue_pixel(pick_chan(), pick_chan(), pick_chan(), $urandom_range(0, 99) < 2);
      end
      rnd_phase++;
    end

    wait_drained();
    calm = 1'b0;
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    if (predicted_px.size() != 0) begin
      fail_count++;
      $error("%0d predicted results never arrived", predicted_px.size());
    end
    $display("Covered %0d register settings, %0d palette loads, %0d pixel results, %0d frame ends,",
             settings_seen, loads_seen, px_checked, frames_seen);
    $display("with widths and sizes at and past their caps, zero registers and random stalls.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
